@@ rtl/core/dmc_pkg.sv @@
// Shared types and constants for the direct-mapped cache tag check unit.
// No dependencies; used by every module under rtl/core.
package dmc_pkg;

    // Default number of lines in the tag store
    localparam int DMC_LINES = 4096;

    // Field widths
    localparam int ADDR_W    = 32;
    localparam int CNT_W     = 32;
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;

    // Masked index before folding onto the store (index_bits up to 15)
    localparam int VIDX_W = 15;

    // Widest line index the store may need (16384 lines)
    localparam int LINE_MAX_W = 14;

    // Depth of the request queue between front and back
    localparam int QDEPTH = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 2'd1;

    // Configuration reset values
    localparam logic [CFG_W-1:0] OFFSET_BITS_RST = 4'd4;
    localparam logic [CFG_W-1:0] INDEX_BITS_RST  = 4'd8;

    // One classified request on its way to the back end
    typedef struct packed {
        logic [LINE_MAX_W-1:0] line;
        logic [ADDR_W-1:0]     tag;
    } t_qent;

endpackage

@@ rtl/core/dmc_front.sv @@
// Front end: configuration registers, address split and line fold.
// Depends on dmc_pkg.
module dmc_front #(
    parameter int LINES = dmc_pkg::DMC_LINES
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_clr_done,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [dmc_pkg::ADDR_W-1:0]   i_address,
    input  logic                         i_cfg_valid,
    input  logic [dmc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [dmc_pkg::CFG_W-1:0]    i_cfg_data,
    output logic                         o_push,
    input  logic                         i_q_full,
    output dmc_pkg::t_qent               o_push_data
);
    import dmc_pkg::*;

    localparam int LW = (LINES > 1) ? $clog2(LINES) : 1;
    // Reciprocal for folding the masked index modulo LINES (exact for 15-bit values)
    localparam int RK = VIDX_W + LW;
    localparam logic [16:0] RM = 17'(((64'd1 << RK) + 64'(LINES) - 64'd1) / 64'(LINES));

    logic [CFG_W-1:0]  r_off, r_idx;
    logic              r1_vld, r2_vld;
    logic [VIDX_W-1:0] r1_v, r2_v, r2_q;
    logic [ADDR_W-1:0] r1_tag, r2_tag;
    logic              en, in_acc;
    logic [ADDR_W-1:0] sh;
    logic [15:0]       mask;
    logic [VIDX_W-1:0] n_v;
    logic [ADDR_W-1:0] n_tag;
    logic [31:0]       prod;
    logic [VIDX_W-1:0] rem;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off <= OFFSET_BITS_RST;
            r_idx <= INDEX_BITS_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_OFFSET_BITS) r_off <= i_cfg_data;
            if (i_cfg_index == CFG_INDEX_BITS)  r_idx <= i_cfg_data;
        end
    end

    // Pipeline moves as a whole while the queue has room
    assign en         = !r2_vld || !i_q_full;
    assign o_in_ready = i_clr_done && en;
    assign in_acc     = i_in_valid && o_in_ready;

    // Address split
    assign sh    = i_address >> r_off;
    assign mask  = (16'd1 << r_idx) - 16'd1;
    assign n_v   = sh[VIDX_W-1:0] & mask[VIDX_W-1:0];
    assign n_tag = i_address >> (5'(r_off) + 5'(r_idx));

    // Quotient estimate by reciprocal multiply
    assign prod = 32'(r1_v) * 32'(RM);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= in_acc;
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_v   <= n_v;
            r1_tag <= n_tag;
            r2_v   <= r1_v;
            r2_tag <= r1_tag;
            r2_q   <= VIDX_W'(prod >> RK);
        end
    end

    // Remainder folds the index onto the store
    assign rem    = r2_v - VIDX_W'(r2_q * VIDX_W'(LINES));
    assign o_push = r2_vld && !i_q_full;

    always_comb begin
        o_push_data      = '0;
        o_push_data.line = LINE_MAX_W'(rem[LW-1:0]);
        o_push_data.tag  = r2_tag;
    end

endmodule

@@ rtl/core/dmc_queue.sv @@
// Short request queue between the front and back ends.
// Depends on dmc_pkg.
module dmc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  dmc_pkg::t_qent i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output dmc_pkg::t_qent o_data
);
    import dmc_pkg::*;

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    t_qent           r_ent [QDEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [PW:0]     r_cnt;

    assign o_full  = (r_cnt == (PW+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_ent[r_rp];

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == PW'(QDEPTH-1)) ? '0 : r_wp + 1'b1;
            if (i_pop)  r_rp <= (r_rp == PW'(QDEPTH-1)) ? '0 : r_rp + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (i_pop && !i_push) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_ent[r_wp] <= i_data;
    end

endmodule

@@ rtl/core/dmc_back.sv @@
// Back end: tag store with clearing pass, hit check, counters, result register.
// Depends on dmc_pkg.
module dmc_back #(
    parameter int LINES = dmc_pkg::DMC_LINES
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    output logic                       o_clr_done,
    input  logic                       i_q_empty,
    input  dmc_pkg::t_qent             i_q_data,
    output logic                       o_pop,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_hit,
    output logic [dmc_pkg::CNT_W-1:0]  o_access_count,
    output logic [dmc_pkg::CNT_W-1:0]  o_miss_total
);
    import dmc_pkg::*;

    localparam int LW = (LINES > 1) ? $clog2(LINES) : 1;

    localparam logic B_IDLE = 1'b0;
    localparam logic B_CMP  = 1'b1;

    // Tag store entry: valid bit over tag
    logic [ADDR_W:0]   r_mem [LINES];
    logic [ADDR_W:0]   r_rd;
    logic              r_state, n_state;
    logic              r_clr_busy;
    logic [LW-1:0]     r_clr_addr;
    logic [LW-1:0]     r_line;
    logic [ADDR_W-1:0] r_tag;
    logic [CNT_W-1:0]  r_acc, r_miss;
    logic              r_out_vld, r_hit;
    logic              out_free, fire, hit, wr_miss;

    assign o_clr_done = !r_clr_busy;
    assign out_free   = !r_out_vld || i_out_ready;
    assign o_pop      = (r_state == B_IDLE) && !r_clr_busy && !i_q_empty;
    assign fire       = (r_state == B_CMP) && out_free;
    assign hit        = r_rd[ADDR_W] && (r_rd[ADDR_W-1:0] == r_tag);
    assign wr_miss    = fire && !hit;

    // Sequencer: read the line, then check and update
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE:  if (o_pop) n_state = B_CMP;
            B_CMP:   if (fire)  n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= B_IDLE;
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_acc      <= '0;
            r_miss     <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state <= n_state;
            // Clearing pass over every line after reset
            if (r_clr_busy) begin
                if (r_clr_addr == LW'(LINES-1)) r_clr_busy <= 1'b0;
                else                            r_clr_addr <= r_clr_addr + 1'b1;
            end
            // Saturating counters
            if (fire) begin
                if (r_acc != '1) r_acc <= r_acc + 1'b1;
                if (!hit && r_miss != '1) r_miss <= r_miss + 1'b1;
            end
            if (fire)             r_out_vld <= 1'b1;
            else if (i_out_ready) r_out_vld <= 1'b0;
        end
    end

    // Request payload and result hit flag
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_line <= i_q_data.line[LW-1:0];
            r_tag  <= i_q_data.tag;
        end
        if (fire) r_hit <= hit;
    end

    // Tag store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (r_clr_busy)   r_mem[r_clr_addr] <= '0;
        else if (wr_miss) r_mem[r_line]     <= {1'b1, r_tag};
        if (o_pop)        r_rd <= r_mem[i_q_data.line[LW-1:0]];
    end

    assign o_out_valid    = r_out_vld;
    assign o_hit          = r_hit;
    assign o_access_count = r_acc;
    assign o_miss_total   = r_miss;

endmodule

@@ rtl/core/direct_mapped_cache_tag_check_unit.sv @@
// Direct-mapped cache tag check: top level joining front end, queue and back end.
// Depends on dmc_pkg, dmc_front, dmc_queue, dmc_back.
//
// Each request is a 32-bit byte address; the offset_bits and index_bits
// registers split it into offset, line index (folded modulo LINES) and tag.
// Every request returns one result: hit flag plus saturating access and
// miss counts that include this request. After reset the block sweeps the
// tag store, one line per cycle, and holds o_in_ready low meanwhile;
// configuration writes are taken at any time (o_cfg_ready is always high)
// but should only be issued while no request is in flight.
// The front end takes one request per cycle until its two-entry queue is
// full. The back end reads the line from the tag store, then compares
// and writes back on a miss, taking no new request until that one is done
// (a stalled result register holds it). Requests pass the front-end
// registers, the queue, then the back end's read and compare steps.
module direct_mapped_cache_tag_check_unit #(
    parameter int LINES = dmc_pkg::DMC_LINES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [dmc_pkg::ADDR_W-1:0]    i_address,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_hit,
    output logic [dmc_pkg::CNT_W-1:0]     o_access_count,
    output logic [dmc_pkg::CNT_W-1:0]     o_miss_total,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [dmc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [dmc_pkg::CFG_W-1:0]     i_cfg_data
);
    import dmc_pkg::*;

    logic  clr_done, push, q_full, q_empty, pop;
    t_qent push_data, q_data;

    assign o_cfg_ready = 1'b1;

    // Accept and classify
    dmc_front #(.LINES(LINES)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clr_done  (clr_done),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_address   (i_address),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_push      (push),
        .i_q_full    (q_full),
        .o_push_data (push_data)
    );

    // Decoupling queue
    dmc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_data  (q_data)
    );

    // Lookup, update and count
    dmc_back #(.LINES(LINES)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .o_clr_done     (clr_done),
        .i_q_empty      (q_empty),
        .i_q_data       (q_data),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_hit          (o_hit),
        .o_access_count (o_access_count),
        .o_miss_total   (o_miss_total)
    );

endmodule

@@ sim/direct_mapped_cache_tag_check_unit_tb.sv @@
`timescale 1ns / 100ps
// Testbench for direct_mapped_cache_tag_check_unit: a cache model scores each result.
// Depends on dmc_pkg and the RTL under rtl/core; needs no files or arguments.
module direct_mapped_cache_tag_check_unit_tb;

    import dmc_pkg::*;

    localparam int LINES_N     = DMC_LINES;
    localparam int SETTLE      = 12;
    localparam int HOLD_CYCLES = 90;
    localparam int TIMEOUT_NS  = 2_000_000;

    // Indexes past the two real registers; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    typedef struct {
        logic              hit;
        logic [CNT_W-1:0]  accesses;
        logic [CNT_W-1:0]  misses;
    } t_lookup_result;

    // Cache model: tag store, counters and split registers
    class cache_scoreboard;
        bit               present[LINES_N];
        logic [ADDR_W-1:0] stored_tag[LINES_N];
        logic [CNT_W-1:0] n_access;
        logic [CNT_W-1:0] n_miss;
        logic [CFG_W-1:0] off_w;
        logic [CFG_W-1:0] idx_w;
        t_lookup_result   awaiting[$];
        int               fails;
        int               checked;
        int               hits;

        function new();
            foreach (present[i]) present[i] = 1'b0;
            n_access = '0;
            n_miss   = '0;
            off_w    = OFFSET_BITS_RST;
            idx_w    = INDEX_BITS_RST;
            fails    = 0;
            checked  = 0;
            hits     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx == CFG_OFFSET_BITS)
                off_w = data;
            else if (idx == CFG_INDEX_BITS)
                idx_w = data;
        endfunction

        // Look up one request and queue the result it should produce
        function void note_access(logic [ADDR_W-1:0] addr);
            logic [63:0]       mask;
            int unsigned       line;
            logic [ADDR_W-1:0] tag;
            t_lookup_result    r;
            mask = (64'd1 << idx_w) - 64'd1;
            line = int'((({32'd0, addr} >> off_w) & mask) % LINES_N);
            tag  = addr >> (int'(off_w) + int'(idx_w));
            r.hit = present[line] && (stored_tag[line] == tag);
            if (n_access != '1) n_access = n_access + 1'b1;
            if (!r.hit) begin
                present[line]    = 1'b1;
                stored_tag[line] = tag;
                if (n_miss != '1) n_miss = n_miss + 1'b1;
            end
            r.accesses = n_access;
            r.misses   = n_miss;
            awaiting.insert(awaiting.size(), r);
        endfunction

        function void check_result(logic hit, logic [CNT_W-1:0] acc, logic [CNT_W-1:0] miss);
            t_lookup_result e;
            if (awaiting.size() == 0) begin
                $error("result with no request outstanding: hit=%0d access=%0d miss=%0d",
                       hit, acc, miss);
                fails++;
                return;
            end
            e = awaiting.pop_front();
            checked++;
            if (e.hit) hits++;
            if (hit !== e.hit) begin
                $error("hit mismatch: expected %0d, got %0d", e.hit, hit);
                fails++;
            end
            if (acc !== e.accesses) begin
                $error("access_count mismatch: expected %0d, got %0d", e.accesses, acc);
                fails++;
            end
            if (miss !== e.misses) begin
                $error("miss_total mismatch: expected %0d, got %0d", e.misses, miss);
                fails++;
            end
        endfunction

        function int outstanding();
            return awaiting.size();
        endfunction

        function void close_out();
            if (awaiting.size() != 0) begin
                $error("%0d results never arrived", awaiting.size());
                fails++;
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [ADDR_W-1:0]    i_address;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic                 o_hit;
    logic [CNT_W-1:0]     o_access_count;
    logic [CNT_W-1:0]     o_miss_total;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    cache_scoreboard sb = new();

    bit                in_gaps_on;
    bit                out_stall_on;
    bit                hold_req;
    logic [ADDR_W-1:0] last_addr;
    logic [ADDR_W-1:0] tag_pool[8];
    int unsigned       win_base;
    int                n_sent;
    int                n_settings;

    logic [ADDR_W-1:0] warmup_addrs[14] = '{
        32'h0000_0000, 32'h0000_0000, 32'h0000_000F, 32'hFFFF_FFFF,
        32'hFFFF_FFF0, 32'h0000_0010, 32'h0000_1000, 32'h0000_0000,
        32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0FF0, 32'hAAAA_AAAA,
        32'h5555_5555, 32'hAAAA_AAAA
    };

    direct_mapped_cache_tag_check_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_address      (i_address),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_hit          (o_hit),
        .o_access_count (o_access_count),
        .o_miss_total   (o_miss_total),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // 2 ns clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 99) < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Addresses drawn mostly from a small working set so lines get reused
    function automatic logic [ADDR_W-1:0] pick_address();
        int unsigned sel;
        int unsigned shift;
        logic [63:0] omask;
        logic [63:0] imask;
        logic [63:0] a;
        sel   = $urandom_range(0, 99);
        shift = int'(sb.off_w) + int'(sb.idx_w);
        omask = (64'd1 << sb.off_w) - 64'd1;
        imask = (64'd1 << sb.idx_w) - 64'd1;
        if (sel < 10)
            return $urandom();
        if (sel < 30) begin
            a = ({32'd0, last_addr} & ~omask) | ({32'd0, $urandom()} & omask);
            return a[ADDR_W-1:0];
        end
        a = ({32'd0, tag_pool[$urandom_range(0, 7)]} << shift)
          | (((win_base + $urandom_range(0, 15)) & imask) << sb.off_w)
          | ({32'd0, $urandom()} & omask);
        return a[ADDR_W-1:0];
    endfunction

    // Offer one request, optionally after an idle gap; returns once accepted
    task automatic send_access(input logic [ADDR_W-1:0] addr);
        int unsigned gap;
        gap = (in_gaps_on && $urandom_range(0, 99) < 35) ? pick_gap() : 0;
        @(negedge i_clk);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_address  <= addr;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_access(addr);
        last_addr = addr;
        n_sent++;
    endtask

    // Register write once the block has gone quiet
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_split(input logic [CFG_W-1:0] ob, input logic [CFG_W-1:0] ib);
        write_reg(CFG_OFFSET_BITS, ob);
        write_reg(CFG_INDEX_BITS, ib);
        n_settings++;
    endtask

    // One random phase under a given split
    task automatic run_phase(input logic [CFG_W-1:0] ob, input logic [CFG_W-1:0] ib,
                             input int n, input bit in_gaps, input bit out_stall,
                             input bit pressure);
        set_split(ob, ib);
        in_gaps_on   = in_gaps && !pressure;
        out_stall_on = out_stall;
        tag_pool[0]  = '0;
        tag_pool[1]  = '1;
        for (int i = 2; i < 8; i++)
            tag_pool[i] = (i < 5) ? $urandom_range(0, 7) : $urandom();
        win_base = $urandom();
        if (pressure) hold_req = 1'b1;
        for (int i = 0; i < n; i++)
            send_access(pick_address());
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else if (out_stall_on && $urandom_range(0, 99) < 30) begin
                i_out_ready <= 1'b0;
                repeat (pick_gap()) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(negedge i_clk);
        end
    end

    // Result monitor
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready)
                sb.check_result(o_hit, o_access_count, o_miss_total);
        end
    end

    // Main sequence
    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_address    = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        in_gaps_on   = 1'b0;
        out_stall_on = 1'b0;
        hold_req     = 1'b0;
        last_addr    = '0;
        n_sent       = 0;
        n_settings   = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Writes to the unused indexes (not scored: the split is set anew before any request)
        write_reg(CFG_SPARE_2, 4'hF);
        write_reg(CFG_SPARE_3, 4'h5);

        // Directed: hits, offset-only changes, conflicts and extreme addresses
        set_split(4'd4, 4'd8);
        foreach (warmup_addrs[i]) send_access(warmup_addrs[i]);

        // Widest split: index folds onto the store, lines kept across the change
        set_split(4'd15, 4'd15);
        send_access(32'h0000_0000);
        send_access(32'h4000_0000);
        send_access(32'h0800_0000);
        send_access(32'hFFFF_FFFF);

        // No offset, no index: every address maps to line 0
        set_split(4'd0, 4'd0);
        send_access(32'h0000_0001);
        send_access(32'h0000_0001);
        send_access(32'hFFFF_FFFF);
        send_access(32'h0000_0000);

        // Random phases over the split range, gaps and stalls varied
        run_phase(4'd4,  4'd8,  130, 1'b0, 1'b0, 1'b0);
        run_phase(4'd0,  4'd0,  110, 1'b1, 1'b1, 1'b0);
        run_phase(4'd12, 4'd12, 130, 1'b1, 1'b0, 1'b0);
        run_phase(4'd15, 4'd15, 120, 1'b0, 1'b1, 1'b0);
        run_phase(4'd0,  4'd15, 130, 1'b1, 1'b1, 1'b1);
        run_phase(4'd15, 4'd0,  110, 1'b1, 1'b1, 1'b0);
        run_phase(4'd2,  4'd12, 130, 1'b0, 1'b1, 1'b0);
        run_phase(4'd6,  4'd13, 130, 1'b1, 1'b0, 1'b0);
        run_phase(4'd3,  4'd5,  130, 1'b1, 1'b1, 1'b0);
        run_phase(4'd0,  4'd12, 130, 1'b0, 1'b0, 1'b0);
        run_phase(4'd12, 4'd0,  110, 1'b1, 1'b1, 1'b0);
        run_phase(4'd5,  4'd14, 130, 1'b1, 1'b1, 1'b0);
        run_phase(4'd4,  4'd8,  130, 1'b1, 1'b1, 1'b0);

        // Drain and let the pipeline settle
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        sb.close_out();

        $display("Run covered %0d requests (%0d hits) checked across %0d register settings,",
                 sb.checked, sb.hits, n_settings);
        $display("offset and index widths 0 to 15, idle gaps, stalls and a full-queue hold-off.");
        if (sb.fails == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("Timed out with %0d results outstanding", sb.outstanding());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
